>>> rtl/assert_macros.svh
// assertion macros used by the checker file vmh_checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the rising clock, off while reset is held
`define VMH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vmh assertion failed");

// antecedent this cycle, consequent in the next cycle
`define VMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vmh assertion failed");

`endif

>>> rtl/vmh_pkg.sv
// types, codes and thresholds of the vibration and motion hazard monitor
// no dependencies; used by every other file of the block but assert_macros.svh
package vmh_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_CAL  = 2'd1,
    MODE_MON  = 2'd2
  } op_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OP_MODE     = 3'd0,
    REG_RES_SEED    = 3'd1,
    REG_MOTION_HOLD = 3'd2,
    REG_PEAK_HOLD   = 3'd3,
    REG_HAZARD_ON   = 3'd4,
    REG_COUNT_LIMIT = 3'd5
  } cfg_idx_e;

  // register reset values
  localparam logic [1:0] RST_OP_MODE     = 2'd0;
  localparam logic [9:0] RST_RES_SEED    = 10'd160;
  localparam logic [9:0] RST_MOTION_HOLD = 10'd100;
  localparam logic [9:0] RST_PEAK_HOLD   = 10'd60;
  localparam logic [3:0] RST_HAZARD_ON   = 4'd5;
  localparam logic [3:0] RST_COUNT_LIMIT = 4'd10;

  // squared accel magnitude bounds, raw units (1 g = 16384 lsb)
  // motion band 0.85..1.15 g: floor of the rational bound, compared > and <=
  localparam logic [31:0] ACC_MOTION_HI = 32'((64'd529 << 24) / 64'd25);
  localparam logic [31:0] ACC_MOTION_LO = 32'((64'd289 << 24) / 64'd25);
  // tap band 0.75..1.25 g, exact in raw units
  localparam logic [31:0] ACC_TAP_HI    = 32'(64'd25 << 24);
  localparam logic [31:0] ACC_TAP_LO    = 32'(64'd9 << 24);
  // squared gyro limits, (20 dps * 131)^2 and (35 dps * 131)^2
  localparam logic [31:0] GYRO_MOTION_SQ = 32'd6864400;
  localparam logic [31:0] GYRO_TAP_SQ    = 32'd21022225;

  localparam logic [11:0] MAG_QUARTER_G     = 12'd64;
  localparam logic [11:0] MAG_HIGH_LIMIT    = 12'd460;
  localparam logic [15:0] ENERGY_HIGH_LIMIT = 16'd640;
  localparam logic [9:0]  FREQ_MIN_LOCK     = 10'd32;
  localparam logic [9:0]  FREQ_MAX_LOCK     = 10'd720;
  localparam logic [9:0]  FREQ_NEAR_TOL     = 10'd40;

  typedef struct packed {
    logic               sensor_ok;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic               frame_valid;
    logic [9:0]         spectrum_peak_freq;
    logic [11:0]        spectrum_peak_mag;
    logic [15:0]        spectrum_band_energy;
    logic               clear_tap;
  } sample_t;

  typedef struct packed {
    logic        motion_detected;
    logic [9:0]  live_freq;
    logic [11:0] live_mag;
    logic [9:0]  locked_freq;
    logic [15:0] last_band_energy;
    logic        hazard;
    logic        tap_seen;
    logic [3:0]  sustain_level;
  } result_t;

  // sample reduced to its motion and tap decisions
  typedef struct packed {
    logic        sensor_ok;
    logic        moving;
    logic        tap;
    logic        frame_valid;
    logic [9:0]  peak_freq;
    logic [11:0] peak_mag;
    logic [15:0] band_energy;
    logic        clear_tap;
  } frame_t;

  typedef struct packed {
    logic [1:0] op_mode;
    logic [9:0] motion_hold;
    logic [9:0] peak_hold;
    logic [3:0] hazard_on_count;
    logic [3:0] count_limit;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic [9:0] value;
  } seed_wr_t;

  typedef struct packed {
    logic sq_load;
    logic fl_load;
    logic out_load;
  } pipe_ctl_t;

endpackage

>>> rtl/vmh_ifs.sv
// request channels of the monitor: sample in, result out, register write
// depends on vmh_pkg
interface vmh_sample_if;
  logic              valid;
  logic              ready;
  vmh_pkg::sample_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vmh_result_if;
  logic              valid;
  logic              ready;
  vmh_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vmh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [vmh_pkg::CFG_IDX_W-1:0]    index;
  logic [vmh_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/vmh_magnitude.sv
// squared accel and gyro magnitudes and the motion and tap decisions
// two register stages; depends on vmh_pkg
module vmh_magnitude (
  input  logic               clk_i,
  input  vmh_pkg::pipe_ctl_t ctl_i,
  input  vmh_pkg::sample_t   sample_i,
  output vmh_pkg::frame_t    frame_o
);

  logic signed [15:0] axis [6];
  logic signed [31:0] prod [6];
  logic [30:0]        sq_d [6];
  logic [30:0]        sq_q [6];
  vmh_pkg::frame_t    pass_d;
  vmh_pkg::frame_t    pass_q;
  vmh_pkg::frame_t    frame_d;
  vmh_pkg::frame_t    frame_q;
  logic [31:0]        acc_sum;
  logic [31:0]        gyr_sum;

  assign axis[0] = sample_i.accel_x;
  assign axis[1] = sample_i.accel_y;
  assign axis[2] = sample_i.accel_z;
  assign axis[3] = sample_i.gyro_x;
  assign axis[4] = sample_i.gyro_y;
  assign axis[5] = sample_i.gyro_z;

  // a square of a 16 bit value is at most 2^30
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      prod[k] = axis[k] * axis[k];
      sq_d[k] = prod[k][30:0];
    end
  end

  always_comb begin
    pass_d             = '0;
    pass_d.sensor_ok   = sample_i.sensor_ok;
    pass_d.frame_valid = sample_i.frame_valid;
    pass_d.peak_freq   = sample_i.spectrum_peak_freq;
    pass_d.peak_mag    = sample_i.spectrum_peak_mag;
    pass_d.band_energy = sample_i.spectrum_band_energy;
    pass_d.clear_tap   = sample_i.clear_tap;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sq_load) begin
      sq_q   <= sq_d;
      pass_q <= pass_d;
    end
  end

  // three squares sum below 2^32
  assign acc_sum = 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
  assign gyr_sum = 32'(sq_q[3]) + 32'(sq_q[4]) + 32'(sq_q[5]);

  always_comb begin
    frame_d        = pass_q;
    frame_d.moving = (acc_sum > vmh_pkg::ACC_MOTION_HI) ||
                     (acc_sum <= vmh_pkg::ACC_MOTION_LO) ||
                     (gyr_sum > vmh_pkg::GYRO_MOTION_SQ);
    frame_d.tap    = (acc_sum > vmh_pkg::ACC_TAP_HI) ||
                     (acc_sum < vmh_pkg::ACC_TAP_LO) ||
                     (gyr_sum > vmh_pkg::GYRO_TAP_SQ);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fl_load) begin
      frame_q <= frame_d;
    end
  end

  assign frame_o = frame_q;

endmodule

>>> rtl/vmh_tracker.sv
// motion hold, tap latch, resonance lock, live peak, sustain counter, hazard
// state doubles as the result register; depends on vmh_pkg
module vmh_tracker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  vmh_pkg::frame_t   frame_i,
  input  vmh_pkg::cfg_t     cfg_i,
  input  vmh_pkg::seed_wr_t seed_i,
  output vmh_pkg::result_t  result_o
);

  logic        motion_flag_q, motion_flag_d;
  logic        hazard_q, hazard_d;
  logic        tap_q, tap_d;
  logic [9:0]  motion_timer_q, motion_timer_d;
  logic [9:0]  peak_timer_q, peak_timer_d;
  logic [9:0]  held_freq_q, held_freq_d;
  logic [11:0] held_mag_q, held_mag_d;
  logic [15:0] held_energy_q, held_energy_d;
  logic [9:0]  lock_q, lock_d;
  logic [3:0]  sustain_q, sustain_d;
  logic [9:0]  gated;
  logic [9:0]  diff;
  logic        near;
  logic        high;

  always_comb begin
    tap_d          = tap_q & ~frame_i.clear_tap;
    motion_timer_d = (motion_timer_q != '0) ? motion_timer_q - 10'd1 : motion_timer_q;
    peak_timer_d   = (peak_timer_q != '0) ? peak_timer_q - 10'd1 : peak_timer_q;
    motion_flag_d  = motion_flag_q;
    hazard_d       = hazard_q;
    held_freq_d    = held_freq_q;
    held_mag_d     = held_mag_q;
    held_energy_d  = held_energy_q;
    lock_d         = lock_q;
    sustain_d      = sustain_q;
    gated          = '0;
    diff           = '0;
    near           = 1'b0;
    high           = 1'b0;

    if (!frame_i.sensor_ok) begin
      motion_flag_d = 1'b0;
      hazard_d      = 1'b0;
    end else begin
      if (frame_i.moving) begin
        motion_timer_d = cfg_i.motion_hold;
        motion_flag_d  = 1'b1;
      end else if (motion_timer_d == '0) begin
        motion_flag_d = 1'b0;
      end

      if (frame_i.frame_valid && (cfg_i.op_mode == vmh_pkg::MODE_CAL)) begin
        if (frame_i.tap) begin
          tap_d = 1'b1;
        end
        held_freq_d = frame_i.peak_freq;
        held_mag_d  = frame_i.peak_mag;
        if (tap_d && (frame_i.peak_mag > vmh_pkg::MAG_QUARTER_G) &&
            (frame_i.peak_freq >= vmh_pkg::FREQ_MIN_LOCK) &&
            (frame_i.peak_freq <= vmh_pkg::FREQ_MAX_LOCK)) begin
          lock_d = frame_i.peak_freq;
        end
      end else if (frame_i.frame_valid && (cfg_i.op_mode == vmh_pkg::MODE_MON)) begin
        // noise gate: quiet and weak peaks count as no peak
        gated = (!motion_flag_d && (frame_i.peak_mag < vmh_pkg::MAG_QUARTER_G)) ?
                '0 : frame_i.peak_freq;
        if (gated != '0) begin
          held_freq_d  = gated;
          held_mag_d   = frame_i.peak_mag;
          peak_timer_d = cfg_i.peak_hold;
        end else if (peak_timer_d == '0) begin
          held_freq_d = '0;
          held_mag_d  = '0;
        end
        held_energy_d = frame_i.band_energy;

        diff = (held_freq_d > lock_q) ? held_freq_d - lock_q : lock_q - held_freq_d;
        near = (held_freq_d != '0) && (diff <= vmh_pkg::FREQ_NEAR_TOL);
        high = (frame_i.band_energy > vmh_pkg::ENERGY_HIGH_LIMIT) ||
               (frame_i.peak_mag > vmh_pkg::MAG_HIGH_LIMIT);

        if (near && high) begin
          if (sustain_q < cfg_i.count_limit) begin
            sustain_d = sustain_q + 4'd1;
          end
        end else if (sustain_q != '0) begin
          sustain_d = sustain_q - 4'd1;
        end

        // hysteresis: set at the on level, clear at zero (or when the sensor fails)
        if (sustain_d >= cfg_i.hazard_on_count) begin
          hazard_d = 1'b1;
        end else if (sustain_d == '0) begin
          hazard_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_flag_q  <= 1'b0;
      hazard_q       <= 1'b0;
      tap_q          <= 1'b0;
      motion_timer_q <= '0;
      peak_timer_q   <= '0;
      held_freq_q    <= '0;
      held_mag_q     <= '0;
      held_energy_q  <= '0;
      lock_q         <= vmh_pkg::RST_RES_SEED;
      sustain_q      <= '0;
    end else begin
      if (load_i) begin
        motion_flag_q  <= motion_flag_d;
        hazard_q       <= hazard_d;
        tap_q          <= tap_d;
        motion_timer_q <= motion_timer_d;
        peak_timer_q   <= peak_timer_d;
        held_freq_q    <= held_freq_d;
        held_mag_q     <= held_mag_d;
        held_energy_q  <= held_energy_d;
        sustain_q      <= sustain_d;
      end
      if (seed_i.load) begin
        lock_q <= seed_i.value;
      end else if (load_i) begin
        lock_q <= lock_d;
      end
    end
  end

  assign result_o.motion_detected  = motion_flag_q;
  assign result_o.live_freq        = held_freq_q;
  assign result_o.live_mag         = held_mag_q;
  assign result_o.locked_freq      = lock_q;
  assign result_o.last_band_energy = held_energy_q;
  assign result_o.hazard           = hazard_q;
  assign result_o.tap_seen         = tap_q;
  assign result_o.sustain_level    = sustain_q;

endmodule

>>> rtl/vibration_motion_hazard_monitor.sv
// a result is valid once its sample has passed all four pipeline registers
// throughput: one sample per cycle unless a stalled result holds the pipe,
//   set by the pipeline (input, squares, motion/tap compares, state update)
// reset: state and config to defaults, pipeline empty, lock 160
// depends on vmh_pkg, vmh_ifs, vmh_magnitude, vmh_tracker
module vibration_motion_hazard_monitor (
  input  logic         clk_i,
  input  logic         rst_ni,
  vmh_sample_if.sink   sample_i,
  vmh_result_if.source result_o,
  vmh_cfg_if.sink      cfg_i
);

  // pipeline occupancy
  logic               v_in_q, v_sq_q, v_fl_q, v_out_q;
  logic               in_load;
  logic               in_free, sq_free, fl_free;
  vmh_pkg::pipe_ctl_t ctl;
  vmh_pkg::sample_t   in_q;
  vmh_pkg::frame_t    frame;
  vmh_pkg::cfg_t      cfg_q;
  vmh_pkg::seed_wr_t  seed_wr;
  logic               cfg_we;

  // each stage moves on when the one below is empty or moving too,
  // so a stalled result still leaves room for new samples behind it
  assign ctl.out_load = v_fl_q && (!v_out_q || result_o.ready);
  assign fl_free      = !v_fl_q || ctl.out_load;
  assign ctl.fl_load  = v_sq_q && fl_free;
  assign sq_free      = !v_sq_q || ctl.fl_load;
  assign ctl.sq_load  = v_in_q && sq_free;
  assign in_free      = !v_in_q || ctl.sq_load;
  assign in_load      = sample_i.valid && in_free;

  assign sample_i.ready = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_sq_q  <= 1'b0;
      v_fl_q  <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (in_free) begin
        v_in_q <= sample_i.valid;
      end
      if (sq_free) begin
        v_sq_q <= v_in_q;
      end
      if (fl_free) begin
        v_fl_q <= v_sq_q;
      end
      if (!v_out_q || result_o.ready) begin
        v_out_q <= v_fl_q;
      end
    end
  end

  // input register, payload only
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= sample_i.data;
    end
  end

  // register writes are always taken
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // the seed write goes straight into the resonance lock
  assign seed_wr.load  = cfg_we && (cfg_i.index == vmh_pkg::REG_RES_SEED);
  assign seed_wr.value = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_mode         <= vmh_pkg::RST_OP_MODE;
      cfg_q.motion_hold     <= vmh_pkg::RST_MOTION_HOLD;
      cfg_q.peak_hold       <= vmh_pkg::RST_PEAK_HOLD;
      cfg_q.hazard_on_count <= vmh_pkg::RST_HAZARD_ON;
      cfg_q.count_limit     <= vmh_pkg::RST_COUNT_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        vmh_pkg::REG_OP_MODE:     cfg_q.op_mode         <= cfg_i.data[1:0];
        vmh_pkg::REG_MOTION_HOLD: cfg_q.motion_hold     <= cfg_i.data;
        vmh_pkg::REG_PEAK_HOLD:   cfg_q.peak_hold       <= cfg_i.data;
        vmh_pkg::REG_HAZARD_ON:   cfg_q.hazard_on_count <= cfg_i.data[3:0];
        vmh_pkg::REG_COUNT_LIMIT: cfg_q.count_limit     <= cfg_i.data[3:0];
        default: begin
          // seed is handled by the tracker, other indexes are ignored
        end
      endcase
    end
  end

  // squares, then motion and tap compares
  vmh_magnitude u_magnitude (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .sample_i (in_q),
    .frame_o  (frame)
  );

  // state update; its registers hold the pending result
  vmh_tracker u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (ctl.out_load),
    .frame_i  (frame),
    .cfg_i    (cfg_q),
    .seed_i   (seed_wr),
    .result_o (result_o.data)
  );

  assign result_o.valid = v_out_q;

endmodule

>>> rtl/vmh_checker.sv
// port-level checks of the monitor, bound to the top level
// depends on vmh_pkg and assert_macros.svh
`include "assert_macros.svh"

module vmh_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input vmh_pkg::result_t out_data_i
);

  logic in_accept;

  assign in_accept = in_valid_i && in_ready_i;

  // backpressure on samples only comes from a stalled result
  `VMH_ASSERT(stall_from_output, !in_ready_i |-> (out_valid_i && !out_ready_i))

  // with the sink taking results, an accepted sample comes out as a valid result
  `VMH_ASSERT_NEXT(result_latency, in_accept ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i)

  // a waiting result stays offered and is checked to keep its value, though a seed write changes its lock
  `VMH_ASSERT_NEXT(result_holds, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

endmodule

bind vibration_motion_hazard_monitor vmh_checker u_vmh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_data_i  (result_o.data)
);
